// File: hw/rtl/retransmit_history_table_top_assert.svh
// assertion macros for the retransmit history table checker
// no dependencies; taken in by the checker file
`ifndef RETRANSMIT_HISTORY_TABLE_TOP_ASSERT_SVH
`define RETRANSMIT_HISTORY_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rht check failed");

// next-cycle implication, disabled in reset
`define RHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rht check failed");

`endif

// File: hw/rtl/rht_pkg.sv
// shared types and constants for the retransmit history table
// no dependencies
`default_nettype none

package rht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LIMIT_W     = 6;
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int AGE_W       = 16;
  localparam int LIMIT_US_W  = 26;
  localparam int EVC_W       = 7;
  localparam int GRP_SIZE    = 8;
  localparam int NGRP        = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;
  localparam logic [AGE_W-1:0]   AGE_RESET   = 16'd1000;
  localparam logic [9:0]         MS_TO_US    = 10'd1000;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT   = 2'd1;

  // action codes
  localparam logic ACT_SAVE = 1'b0;
  localparam logic ACT_FIND = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] now_us;
    logic [31:0] seq_num;
    logic [7:0]  fec_k;
    logic [7:0]  group_index;
    logic [31:0] packet_handle;
  } rht_in_t;

  typedef struct packed {
    logic             found;
    logic [31:0]      handle_out;
    logic             stored;
    logic             full_drop;
    logic [EVC_W-1:0] evicted_count;
  } rht_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [63:0] tstamp;
    logic [31:0] handle;
  } rht_entry_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic shift_dn;
    logic insert;
    logic probe;
  } rht_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/rht_cell.sv
// one table cell: holds one entry, shifts down on eviction, shifts up on insert
// depends on rht_pkg
`default_nettype none

module rht_cell
  import rht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rht_cmd_t   cmd,
  input  wire rht_entry_t new_ent,
  input  wire rht_entry_t prev_ent,
  input  wire rht_entry_t next_ent,
  input  wire logic       prev_gt,
  output rht_entry_t      ent,
  output logic            gt,
  output logic            hit,
  output logic [31:0]     hit_handle
);

  logic        valid_r, valid_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] tstamp_r, tstamp_nxt;
  logic [31:0] handle_r, handle_nxt;
  logic        hit_r;
  logic [31:0] hh_r;
  logic        match;

  assign ent        = '{valid: valid_r, key: key_r, tstamp: tstamp_r, handle: handle_r};
  assign gt         = !valid_r || (key_r > new_ent.key);
  assign match      = valid_r && (key_r == new_ent.key);
  assign hit        = hit_r;
  assign hit_handle = hh_r;

  // shift down, sorted insert, or hold
  always_comb begin
    valid_nxt  = valid_r;
    key_nxt    = key_r;
    tstamp_nxt = tstamp_r;
    handle_nxt = handle_r;
    if (cmd.shift_dn) begin
      valid_nxt  = next_ent.valid;
      key_nxt    = next_ent.key;
      tstamp_nxt = next_ent.tstamp;
      handle_nxt = next_ent.handle;
    end else if (cmd.insert && gt) begin
      if (prev_gt) begin
        valid_nxt  = prev_ent.valid;
        key_nxt    = prev_ent.key;
        tstamp_nxt = prev_ent.tstamp;
        handle_nxt = prev_ent.handle;
      end else begin
        valid_nxt  = 1'b1;
        key_nxt    = new_ent.key;
        tstamp_nxt = new_ent.tstamp;
        handle_nxt = new_ent.handle;
      end
    end
  end

  // valid and hit flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.probe) begin
        hit_r <= match;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    tstamp_r <= tstamp_nxt;
    handle_r <= handle_nxt;
    if (cmd.probe) begin
      hh_r <= match ? handle_r : 32'd0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rht_chain.sv
// row of table cells kept sorted by key, plus registered hit reduction
// depends on rht_pkg and rht_cell
`default_nettype none

module rht_chain
  import rht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rht_cmd_t   cmd,
  input  wire rht_entry_t new_ent,
  output rht_entry_t      head,
  output logic            hit_any,
  output logic [31:0]     hit_handle
);

  localparam int PAD = NGRP * GRP_SIZE;

  rht_entry_t  ents [TABLE_DEPTH];
  logic        gts  [TABLE_DEPTH];
  logic        hits [PAD];
  logic [31:0] hhs  [PAD];
  logic        grp_hit_r [NGRP];
  logic [31:0] grp_hh_r  [NGRP];

  // cells, neighbor wiring
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rht_entry_t prev_e, next_e;
    logic       prev_g;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = ents[i-1];
      assign prev_g = gts[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ents[i+1];
    end
    rht_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_ent    (new_ent),
      .prev_ent   (prev_e),
      .next_ent   (next_e),
      .prev_gt    (prev_g),
      .ent        (ents[i]),
      .gt         (gts[i]),
      .hit        (hits[i]),
      .hit_handle (hhs[i])
    );
  end

  // pad the hit vector up to whole groups
  for (genvar p = TABLE_DEPTH; p < PAD; p++) begin : g_pad
    assign hits[p] = 1'b0;
    assign hhs[p]  = 32'd0;
  end

  // first reduction level, one register per group
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic        acc_hit;
    logic [31:0] acc_hh;
    always_comb begin
      acc_hit = 1'b0;
      acc_hh  = 32'd0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        acc_hit = acc_hit | hits[g*GRP_SIZE + j];
        acc_hh  = acc_hh | hhs[g*GRP_SIZE + j];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        grp_hit_r[g] <= 1'b0;
      end else begin
        grp_hit_r[g] <= acc_hit;
      end
    end
    always_ff @(posedge clk) begin
      grp_hh_r[g] <= acc_hh;
    end
  end

  // final level over the groups
  always_comb begin
    hit_any    = 1'b0;
    hit_handle = 32'd0;
    for (int g = 0; g < NGRP; g++) begin
      hit_any    = hit_any | grp_hit_r[g];
      hit_handle = hit_handle | grp_hh_r[g];
    end
  end

  assign head = ents[0];

endmodule

`default_nettype wire

// File: hw/rtl/retransmit_history_table_top.sv
// find: S_PROBE, S_RED1 and S_RED2, then the result word; save: evictions from the
// head, one per cycle through the cell row, then the probe states and S_INSERT; no
// insert when the key is held or the table is full, and a repair packet goes to the
// result after eviction. one word in flight; the next is taken the cycle after its
// result loads. synchronous active-low reset empties the table and sets entry_limit
// to 63 and age_limit_ms to 1000; no clearing pass. depends on rht_pkg and rht_chain
`default_nettype none

module retransmit_history_table_top
  import rht_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rht_in_t              in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rht_out_t                  out_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [AGE_W-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVICT  = 3'd1;
  localparam logic [2:0] S_PROBE  = 3'd2;
  localparam logic [2:0] S_RED1   = 3'd3;
  localparam logic [2:0] S_RED2   = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]            state_r, state_nxt;
  rht_in_t               item_r;
  logic [LIMIT_US_W-1:0] limit_us_r;
  logic [LIMIT_W-1:0]    entry_limit_r;
  logic [AGE_W-1:0]      age_limit_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [EVC_W-1:0]      evc_r, evc_nxt;
  logic                  found_r, found_nxt;
  logic [31:0]           hout_r, hout_nxt;
  logic                  stored_r, stored_nxt;
  logic                  drop_r, drop_nxt;
  logic                  out_valid_r;
  rht_out_t              out_word_r;

  rht_cmd_t   cmd;
  rht_entry_t new_ent;
  rht_entry_t head;
  logic       hit_any;
  logic [31:0] hit_handle;
  logic       accept, over_count, too_old, evict, repair, load_out;
  logic [64:0] old_edge;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign new_ent = '{valid: 1'b1, key: item_r.seq_num, tstamp: item_r.now_us,
                     handle: item_r.packet_handle};

  // eviction test on the lowest key, which always sits in the first cell
  assign over_count = CMP_W'(cnt_r) > CMP_W'(entry_limit_r);
  assign old_edge   = {1'b0, head.tstamp} + 65'(limit_us_r);
  assign too_old    = {1'b0, item_r.now_us} > old_edge;
  assign evict      = head.valid && (over_count || too_old);
  assign repair     = (item_r.fec_k != 8'd0) && (item_r.group_index >= item_r.fec_k);

  always_comb begin
    cmd.shift_dn = (state_r == S_EVICT) && evict;
    cmd.insert   = (state_r == S_INSERT);
    cmd.probe    = (state_r == S_PROBE);
  end

  rht_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .new_ent    (new_ent),
    .head       (head),
    .hit_any    (hit_any),
    .hit_handle (hit_handle)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    evc_nxt    = evc_r;
    found_nxt  = found_r;
    hout_nxt   = hout_r;
    stored_nxt = stored_r;
    drop_nxt   = drop_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          evc_nxt    = '0;
          found_nxt  = 1'b0;
          hout_nxt   = 32'd0;
          stored_nxt = 1'b0;
          drop_nxt   = 1'b0;
          state_nxt  = (in_word.action == ACT_FIND) ? S_PROBE : S_EVICT;
        end
      end
      S_EVICT: begin
        if (evict) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (evc_r != {EVC_W{1'b1}}) begin
            evc_nxt = evc_r + EVC_W'(1);
          end
        end else begin
          state_nxt = repair ? S_DONE : S_PROBE;
        end
      end
      S_PROBE: state_nxt = S_RED1;
      S_RED1:  state_nxt = S_RED2;
      S_RED2: begin
        if (item_r.action == ACT_FIND) begin
          found_nxt = hit_any;
          hout_nxt  = hit_handle;
          state_nxt = S_DONE;
        end else if (hit_any) begin
          state_nxt = S_DONE;
        end else if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
          drop_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cnt_nxt    = cnt_r + CNT_W'(1);
        stored_nxt = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      entry_limit_r <= LIMIT_RESET;
      age_limit_r   <= AGE_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && (cfg_index == REG_ENTRY_LIMIT)) begin
        entry_limit_r <= cfg_wdata[LIMIT_W-1:0];
      end
      if (cfg_we && (cfg_index == REG_AGE_LIMIT)) begin
        age_limit_r <= cfg_wdata;
      end
    end
  end

  // item, result and output word
  always_ff @(posedge clk) begin
    evc_r    <= evc_nxt;
    found_r  <= found_nxt;
    hout_r   <= hout_nxt;
    stored_r <= stored_nxt;
    drop_r   <= drop_nxt;
    if (accept) begin
      item_r     <= in_word;
      limit_us_r <= LIMIT_US_W'(age_limit_r) * LIMIT_US_W'(MS_TO_US);
    end
    if (load_out) begin
      out_word_r <= '{found: found_r, handle_out: hout_r, stored: stored_r,
                      full_drop: drop_r, evicted_count: evc_r};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rht_checker.sv
// port-level checks for the retransmit history table top level
// depends on rht_pkg and retransmit_history_table_top_assert.svh
`default_nettype none

`include "retransmit_history_table_top_assert.svh"

module rht_checker
  import rht_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire rht_in_t              in_word,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire rht_out_t             out_word,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [AGE_W-1:0]     cfg_wdata
);

  // a stalled result word holds
  `RHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

  // a find hit reports nothing of a save
  `RHT_ASSERT_NOW(a_find_clean, clk, rst_n, out_valid && out_word.found, !out_word.stored && !out_word.full_drop && (out_word.evicted_count == '0))

  // handle is zero without a hit
  `RHT_ASSERT_NOW(a_handle_zero, clk, rst_n, out_valid && !out_word.found, out_word.handle_out == 32'd0)

  // a result word is never both stored and dropped
  `RHT_ASSERT_NOW(a_store_drop, clk, rst_n, out_valid, !(out_word.stored && out_word.full_drop))

endmodule

bind retransmit_history_table_top rht_checker u_rht_checker (.*);

`default_nettype wire
